>>> design/sfce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfce_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  PRE_0    = 8'hAA;
  localparam logic [7:0]  PRE_1    = 8'h55;

  // output byte positions inside one expanded item
  localparam logic [2:0] STEP_PRE0   = 3'd0;
  localparam logic [2:0] STEP_PRE1   = 3'd1;
  localparam logic [2:0] STEP_LEN_LO = 3'd2;
  localparam logic [2:0] STEP_LEN_HI = 3'd3;
  localparam logic [2:0] STEP_DATA   = 3'd4;
  localparam logic [2:0] STEP_CRC_LO = 3'd5;
  localparam logic [2:0] STEP_CRC_HI = 3'd6;

  // one classified item, handed from front to back
  typedef struct packed {
    logic        hdr;
    logic        has_byte;
    logic        close;
    logic [15:0] len;
    logic [7:0]  data;
    logic [15:0] crc;
  } sfce_entry_t;

  localparam int ENTRY_W = $bits(sfce_entry_t);

  // crc-16-ccitt, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/sfce_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfce_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         payload_byte,
  input  wire logic [15:0]        payload_length,
  input  wire logic               frame_start,
  output logic                    push,
  output sfce_pkg::sfce_entry_t   entry
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        idle;
  logic [15:0] crc_base;
  logic [15:0] crc_new;

  assign idle     = (rem_r == 16'd0);
  assign crc_base = idle ? sfce_pkg::CRC_INIT : crc_r;
  assign crc_new  = sfce_pkg::crc16_byte(crc_base, payload_byte);

  always_comb begin
    crc_nxt        = crc_r;
    rem_nxt        = rem_r;
    push           = 1'b0;
    entry.hdr      = 1'b0;
    entry.has_byte = 1'b1;
    entry.close    = 1'b0;
    entry.len      = payload_length;
    entry.data     = payload_byte;
    entry.crc      = crc_new;
    if (accept) begin
      if (idle) begin
        if (frame_start) begin
          push      = 1'b1;
          entry.hdr = 1'b1;
          if (payload_length == 16'd0) begin
            // empty payload: header then the initial crc
            entry.has_byte = 1'b0;
            entry.close    = 1'b1;
            entry.crc      = sfce_pkg::CRC_INIT;
          end else begin
            entry.close = (payload_length == 16'd1);
            rem_nxt     = payload_length - 16'd1;
            crc_nxt     = entry.close ? sfce_pkg::CRC_INIT : crc_new;
          end
        end
      end else begin
        push        = 1'b1;
        entry.close = (rem_r == 16'd1);
        rem_nxt     = rem_r - 16'd1;
        crc_nxt     = entry.close ? sfce_pkg::CRC_INIT : crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= sfce_pkg::CRC_INIT;
      rem_r <= 16'd0;
    end else begin
      crc_r <= crc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/sfce_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sfce_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire sfce_pkg::sfce_entry_t wr_data,
  input  wire logic                  pop,
  output sfce_pkg::sfce_entry_t      rd_data,
  output logic                       empty,
  output logic                       full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sfce_pkg::sfce_entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == CW'(0));
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> design/sfce_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfce_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sfce_pkg::sfce_entry_t entry,
  input  wire logic                  empty,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  output logic                       out_fend
);

  sfce_pkg::sfce_entry_t cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [2:0] step_r, step_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] obyte_r;
  logic       olast_r, ofend_r;
  logic       load_ok, emit, is_last, cur_free;
  logic [7:0] sel_byte;
  logic [2:0] adv_step;
  logic [2:0] first_step;

  assign load_ok  = !oval_r || out_ready;
  assign emit     = cur_valid_r && load_ok;
  assign cur_free = !cur_valid_r || (emit && is_last);
  assign pop      = !empty && cur_free;

  always_comb begin
    sel_byte = 8'h00;
    adv_step = step_r;
    is_last  = 1'b0;
    case (step_r)
      sfce_pkg::STEP_PRE0: begin
        sel_byte = sfce_pkg::PRE_0;
        adv_step = sfce_pkg::STEP_PRE1;
      end
      sfce_pkg::STEP_PRE1: begin
        sel_byte = sfce_pkg::PRE_1;
        adv_step = sfce_pkg::STEP_LEN_LO;
      end
      sfce_pkg::STEP_LEN_LO: begin
        sel_byte = cur_r.len[7:0];
        adv_step = sfce_pkg::STEP_LEN_HI;
      end
      sfce_pkg::STEP_LEN_HI: begin
        sel_byte = cur_r.len[15:8];
        if (cur_r.has_byte) begin
          adv_step = sfce_pkg::STEP_DATA;
        end else begin
          adv_step = sfce_pkg::STEP_CRC_LO;
        end
      end
      sfce_pkg::STEP_DATA: begin
        sel_byte = cur_r.data;
        adv_step = sfce_pkg::STEP_CRC_LO;
        is_last  = !cur_r.close;
      end
      sfce_pkg::STEP_CRC_LO: begin
        sel_byte = cur_r.crc[7:0];
        adv_step = sfce_pkg::STEP_CRC_HI;
      end
      sfce_pkg::STEP_CRC_HI: begin
        sel_byte = cur_r.crc[15:8];
        is_last  = 1'b1;
      end
      default: begin
        sel_byte = 8'h00;
        is_last  = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (entry.hdr) begin
      first_step = sfce_pkg::STEP_PRE0;
    end else if (entry.has_byte) begin
      first_step = sfce_pkg::STEP_DATA;
    end else begin
      first_step = sfce_pkg::STEP_CRC_LO;
    end
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      step_nxt      = first_step;
    end else if (emit) begin
      cur_valid_nxt = !is_last;
      step_nxt      = adv_step;
    end
    if (emit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      oval_r      <= 1'b0;
      step_r      <= sfce_pkg::STEP_PRE0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      oval_r      <= oval_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= entry;
    end
    if (emit) begin
      obyte_r <= sel_byte;
      olast_r <= is_last;
      ofend_r <= (step_r == sfce_pkg::STEP_CRC_HI);
    end
  end

  assign out_valid = oval_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_fend  = ofend_r;

endmodule

`default_nettype wire

>>> design/serial_frame_crc16_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// path: an item's first byte leaves through the queue, cur_r and the output byte register
// throughput: one input item per cycle while the queue is not full; the output moves one byte
//   per cycle while out_tready is high, set by the single output byte register
// reset: synchronous active-low rst_n clears the queue, the output valid, the byte count (idle)
//   and returns the running crc to ffff; no clearing pass

module serial_frame_crc16_encoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] payload_byte, [23:8] payload_length
  input  wire logic        in_tuser,   // [0] frame_start
  // framed byte stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // run_last: last byte caused by one input item
  output logic             out_tuser   // [0] frame_end: high crc byte that closes a frame
);

  // front: classifies each transfer, tracks the byte count and the running crc
  // queue: classified items waiting for expansion
  // back: expands an item into header, payload byte and crc bytes

  logic                  accept;
  logic                  push;
  logic                  pop;
  logic                  q_empty;
  logic                  q_full;
  sfce_pkg::sfce_entry_t front_entry;
  sfce_pkg::sfce_entry_t q_entry;

  // input stalls only while the queue is full
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  sfce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .payload_byte   (in_tdata[7:0]),
    .payload_length (in_tdata[23:8]),
    .frame_start    (in_tuser),
    .push           (push),
    .entry          (front_entry)
  );

  sfce_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_entry),
    .pop     (pop),
    .rd_data (q_entry),
    .empty   (q_empty),
    .full    (q_full)
  );

  sfce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .entry     (q_entry),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_fend  (out_tuser)
  );

  // a frame always closes on the last byte of its item
  a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame_end without run_last");

  // the front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");

  // nothing is popped from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  // reset leaves no output pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

>>> tb/tb_serial_frame_crc16_encoder.sv
`timescale 1ns / 1ps

module tb_serial_frame_crc16_encoder;

  localparam int CYCLE_LIMIT = 50_000;
  localparam int HOLD_CYCLES = 300;  // long output stall, lets the input side back up
  localparam int RAND_ITEMS  = 100;
  localparam int LAST_LEN    = 24;   // gap-free frame at the end of the run

  // one byte of the framed stream as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fend;
  } out_beat_t;

  // directed rows: either checked by the frame predictor or with a typed expectation
  typedef enum logic [1:0] {ROW_PREDICT, ROW_DROPPED, ROW_EMPTY_FRAME} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  b;
    logic [15:0] len;
    logic        start;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] payload_byte, [23:8] payload_length
  logic        in_tuser = 1'b0; // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic        out_tlast;
  logic        out_tuser;       // [0] frame_end

  // predictor state: running crc and payload bytes still owed by the open frame
  logic [15:0] crc_run = sfce_pkg::CRC_INIT;
  logic [15:0] payload_left = '0;
  out_beat_t   due_bytes[$];

  int errors = 0;
  int items_sent = 0;
  int frames_closed = 0;
  int beats_checked = 0;
  int cycles = 0;
  bit quiet = 1'b0;     // no idling on either side
  bit idle_on = 1'b1;   // sender idling allowed for the current frame
  bit hold_req = 1'b0;  // asks the receiver for one long stall

  dir_row_t directed_rows [17] = '{
    '{ROW_DROPPED,     8'h12, 16'h0000, 1'b0},  // idle, no start
    '{ROW_DROPPED,     8'hFF, 16'hFFFF, 1'b0},  // idle, no start, all ones
    '{ROW_EMPTY_FRAME, 8'hFF, 16'h0000, 1'b1},  // zero length, byte ignored
    '{ROW_EMPTY_FRAME, 8'h00, 16'h0000, 1'b1},
    '{ROW_PREDICT,     8'h00, 16'h0001, 1'b1},  // single-byte frames
    '{ROW_PREDICT,     8'hFF, 16'h0001, 1'b1},
    '{ROW_PREDICT,     8'hA5, 16'h0003, 1'b1},
    '{ROW_PREDICT,     8'h5A, 16'hFFFF, 1'b1},  // start inside an open frame is payload
    '{ROW_PREDICT,     8'hFF, 16'h0000, 1'b0},  // closes the frame
    '{ROW_PREDICT,     8'h80, 16'h0002, 1'b1},
    '{ROW_PREDICT,     8'h7F, 16'h8000, 1'b1},  // start inside, length ignored
    '{ROW_DROPPED,     8'h00, 16'h0000, 1'b0},  // idle again after close
    '{ROW_PREDICT,     8'h3C, 16'h0004, 1'b1},
    '{ROW_PREDICT,     8'hC3, 16'h7FFF, 1'b0},
    '{ROW_PREDICT,     8'hAA, 16'h0000, 1'b0},  // preamble values inside the payload
    '{ROW_PREDICT,     8'h55, 16'h0000, 1'b0},
    '{ROW_DROPPED,     8'h01, 16'h0100, 1'b0}
  };

  serial_frame_crc16_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycles, due_bytes.size());
      $display("serial_frame_crc16_encoder regression: fail");
      $finish;
    end
  end

  // crc-16-ccitt, bit-serial form: feedback is crc msb xor the incoming data bit
  function automatic logic [15:0] ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? sfce_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // frame predictor: advances its state for one accepted transfer and, when keep
  // is set, queues the bytes that transfer should produce
  task automatic predict_frame_bytes(input logic [7:0] b, input logic [15:0] len,
                                     input logic start, input bit keep);
    out_beat_t beats[$];
    bit        has_byte;
    has_byte = 1'b1;
    if (payload_left == 0) begin
      // idle: only a start opens a frame, anything else is dropped
      if (!start) return;
      crc_run = sfce_pkg::CRC_INIT;
      beats.push_back({sfce_pkg::PRE_0, 1'b0, 1'b0});
      beats.push_back({sfce_pkg::PRE_1, 1'b0, 1'b0});
      beats.push_back({len[7:0], 1'b0, 1'b0});
      beats.push_back({len[15:8], 1'b0, 1'b0});
      payload_left = len;
      has_byte = (len != 0);
    end
    if (has_byte) begin
      crc_run = ccitt_step(crc_run, b);
      beats.push_back({b, 1'b0, 1'b0});
      payload_left = payload_left - 16'd1;
    end
    if (payload_left == 0) begin
      // crc trailer, low byte first, high byte closes the frame
      beats.push_back({crc_run[7:0], 1'b0, 1'b0});
      beats.push_back({crc_run[15:8], 1'b0, 1'b1});
      crc_run = sfce_pkg::CRC_INIT;
      frames_closed++;
    end
    beats[beats.size() - 1].last = 1'b1;
    if (keep) begin
      foreach (beats[i]) due_bytes.push_back(beats[i]);
    end
  endtask

  // offers one item and returns at the edge where it transfers
  task automatic send_item(input logic [7:0] b, input logic [15:0] len, input logic start);
    if (!quiet && idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, b};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // a well-formed frame with random payload; now and then a start bit inside it
  task automatic send_frame(input logic [15:0] flen);
    logic [7:0]  b;
    logic [15:0] len;
    logic        st;
    b = $urandom_range(0, 255);
    send_item(b, flen, 1'b1);
    predict_frame_bytes(b, flen, 1'b1, 1'b1);
    for (int k = 1; k < flen; k++) begin
      b   = $urandom_range(0, 255);
      len = $urandom_range(0, 65535);
      st  = ($urandom_range(0, 9) == 0);
      send_item(b, len, st);
      predict_frame_bytes(b, len, st, 1'b1);
    end
  endtask

  // sender goes quiet until every queued byte has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, one long hold on request, none when quiet
  initial begin
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // output checker: every transfer against the oldest queued byte
  always @(posedge clk) begin
    out_beat_t head;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (due_bytes.size() == 0) begin
        $error("unexpected output transfer: out_byte %02h", out_tdata);
        errors++;
      end else begin
        head = due_bytes.pop_front();
        if (out_tdata !== head.data) begin
          $error("out_byte: expected %02h, got %02h", head.data, out_tdata);
          errors++;
        end
        if (out_tlast !== head.last) begin
          $error("run_last: expected %0b, got %0b", head.last, out_tlast);
          errors++;
        end
        if (out_tuser !== head.fend) begin
          $error("frame_end: expected %0b, got %0b", head.fend, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    int          rand_end;
    int          frame_no;
    int          sel;
    logic [15:0] flen;
    logic [7:0]  b;
    logic [15:0] len;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].b, directed_rows[i].len, directed_rows[i].start);
      case (directed_rows[i].kind)
        ROW_PREDICT: begin
          predict_frame_bytes(directed_rows[i].b, directed_rows[i].len,
                              directed_rows[i].start, 1'b1);
        end
        ROW_DROPPED: begin
          // nothing comes out
          predict_frame_bytes(directed_rows[i].b, directed_rows[i].len,
                              directed_rows[i].start, 1'b0);
        end
        ROW_EMPTY_FRAME: begin
          // header with length zero, then the crc of nothing
          predict_frame_bytes(directed_rows[i].b, directed_rows[i].len,
                              directed_rows[i].start, 1'b0);
          due_bytes.push_back({sfce_pkg::PRE_0, 1'b0, 1'b0});
          due_bytes.push_back({sfce_pkg::PRE_1, 1'b0, 1'b0});
          due_bytes.push_back({8'h00, 1'b0, 1'b0});
          due_bytes.push_back({8'h00, 1'b0, 1'b0});
          due_bytes.push_back({8'hFF, 1'b0, 1'b0});
          due_bytes.push_back({8'hFF, 1'b1, 1'b1});
        end
        default: ;
      endcase
    end
    drain_results();

    // random frames with some noise between them
    rand_end = items_sent + RAND_ITEMS;
    frame_no = 0;
    while (items_sent < rand_end) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // stray item while idle, dropped
        b   = $urandom_range(0, 255);
        len = $urandom_range(0, 65535);
        send_item(b, len, 1'b0);
        predict_frame_bytes(b, len, 1'b0, 1'b1);
      end else if (frame_no == 0) begin
        // long output stall while the sender keeps pushing a frame
        hold_req = 1'b1;
        send_frame(16'd40);
        frame_no++;
        drain_results();
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 2)       flen = 16'd0;
        else if (sel < 14) flen = $urandom_range(1, 6);
        else if (sel < 19) flen = $urandom_range(7, 20);
        else               flen = $urandom_range(21, 48);
        send_frame(flen);
        frame_no++;
      end
    end
    drain_results();

    // last part: one frame sent back to back, no idling on either side
    quiet = 1'b1;
    send_frame(16'(LAST_LEN));
    drain_results();
    repeat (10) @(posedge clk);

    $display("%0d input transfers, %0d frames closed, %0d output bytes checked",
             items_sent, frames_closed, beats_checked);
    $display("drops, empty and one-byte frames, starts inside frames, a long stall, no gaps");
    if (errors == 0) begin
      $display("serial_frame_crc16_encoder regression: pass");
    end else begin
      $display("serial_frame_crc16_encoder regression: fail");
    end
    $finish;
  end

endmodule
